/* src/wspd_pkg.sv */
// ============================================================================
// wspd_pkg
// Shared types and constants for the window stack, pointer and drag unit.
// ============================================================================
package wspd_pkg;

  // Table geometry
  localparam int MAX_WINDOWS = 16;
  localparam int IDX_W       = $clog2(MAX_WINDOWS);
  localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);

  // Screen limits and reset values
  localparam logic [12:0] SCREEN_CAP      = 13'd4096;
  localparam logic [12:0] RST_SCREEN_W    = 13'd1024;
  localparam logic [12:0] RST_SCREEN_H    = 13'd768;
  localparam logic [11:0] RST_CURSOR_COL  = 12'd512;
  localparam logic [11:0] RST_CURSOR_ROW  = 12'd384;

  // Configuration register indexes
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // Item kinds
  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_MOUSE  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd2;

  // One window rectangle as held in the table
  typedef struct packed {
    logic signed [12:0] x;
    logic signed [12:0] y;
    logic [11:0]        w;
    logic [11:0]        h;
  } win_entry_t;

  // Latched input transaction
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [12:0] pos_x;
    logic signed [12:0] pos_y;
    logic [11:0]        size_w;
    logic [11:0]        size_h;
    logic [3:0]         remove_index;
    logic signed [8:0]  delta_x;
    logic signed [8:0]  delta_y;
    logic               left_button;
  } item_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_REM_CAP,
    ST_SHIFT_START,
    ST_SHIFT,
    ST_SHIFT_DONE,
    ST_HIT,
    ST_DRAG_CHK,
    ST_DRAG_WR,
    ST_FINISH
  } state_t;

endpackage

/* src/wspd_if.sv */
// ============================================================================
// wspd_if
// Valid/ready channels for input items and result items.
// ============================================================================
interface wspd_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [12:0] pos_x;
  logic signed [12:0] pos_y;
  logic [11:0]        size_w;
  logic [11:0]        size_h;
  logic [3:0]         remove_index;
  logic signed [8:0]  delta_x;
  logic signed [8:0]  delta_y;
  logic               left_button;

  modport source (
    output valid, kind, pos_x, pos_y, size_w, size_h, remove_index,
           delta_x, delta_y, left_button,
    input  ready
  );
  modport sink (
    input  valid, kind, pos_x, pos_y, size_w, size_h, remove_index,
           delta_x, delta_y, left_button,
    output ready
  );
endinterface

interface wspd_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [3:0]         slot;
  logic [4:0]         window_count;
  logic [11:0]        cursor_x;
  logic [11:0]        cursor_y;
  logic               drag_active;
  logic signed [12:0] window_x;
  logic signed [12:0] window_y;

  modport source (
    output valid, status, slot, window_count, cursor_x, cursor_y,
           drag_active, window_x, window_y,
    input  ready
  );
  modport sink (
    input  valid, status, slot, window_count, cursor_x, cursor_y,
           drag_active, window_x, window_y,
    output ready
  );
endinterface

/* src/window_stack_pointer_drag_unit.sv */
// ============================================================================
// window_stack_pointer_drag_unit
// Z-ordered window table with a clamped cursor and drag selection.
// ============================================================================
// The block handles one transaction at a time; the input is not ready from
// acceptance until the result is loaded into the output register. All table
// work goes through one 16-entry memory with one write and one registered
// read port, walked by a small sequencer one entry per cycle. A remove shifts
// every window above the removed slot down by one. A mouse event with a press
// edge tests windows from the top down; a hit shifts the windows above the hit
// one down and writes it on top. The output register lets the block take the
// next transaction while a result waits.
// Configuration writes take effect at once.
// ============================================================================
module window_stack_pointer_drag_unit
  import wspd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [12:0]       cfg_data,
  wspd_req_if.sink          req,
  wspd_rsp_if.source        rsp
);

  // Control state
  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic [11:0]        cursor_col;
  logic [11:0]        cursor_row;
  logic               button_was_down;
  logic               sel_valid;
  logic [IDX_W-1:0]   sel_idx;
  logic [12:0]        screen_w;
  logic [12:0]        screen_h;
  logic               out_valid;

  // Payload registers
  item_t              item;
  logic [IDX_W-1:0]   ptr;
  win_entry_t         hold;
  logic [1:0]         res_status;
  logic [IDX_W-1:0]   res_slot;
  logic signed [12:0] res_x;
  logic signed [12:0] res_y;
  logic [1:0]         out_status;
  logic [IDX_W-1:0]   out_slot;
  logic [CNT_W-1:0]   out_count;
  logic [11:0]        out_col;
  logic [11:0]        out_row;
  logic               out_drag;
  logic signed [12:0] out_x;
  logic signed [12:0] out_y;

  // Window table
  win_entry_t         mem [MAX_WINDOWS];
  win_entry_t         rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  win_entry_t         wr_data;

  // Derived signals
  logic               accept;
  logic               out_free;
  logic               table_full;
  logic               bad_index;
  logic               press_walk;
  logic               hit;
  logic [IDX_W-1:0]   top_idx;
  logic [CNT_W:0]     ptr_ext;
  logic               start_more;
  logic               shift_more;
  logic               drag_ok;
  logic [12:0]        lim_w;
  logic [12:0]        lim_h;
  logic signed [13:0] dx_ext;
  logic signed [13:0] dy_ext;
  logic signed [13:0] col_sum;
  logic signed [13:0] row_sum;
  logic [11:0]        col_next;
  logic [11:0]        row_next;
  logic signed [12:0] drag_x;
  logic signed [12:0] drag_y;
  logic               sel_valid_rm;
  logic [IDX_W-1:0]   sel_idx_rm;

  // Saturate a 14-bit signed sum to the 13-bit signed range
  function automatic logic signed [12:0] sat13(input logic signed [13:0] v);
    logic signed [12:0] r;
    if (v[13] && !v[12]) begin
      r = 13'sh1000;
    end else if (!v[13] && v[12]) begin
      r = 13'sh0FFF;
    end else begin
      r = v[12:0];
    end
    return r;
  endfunction

  wspd_hit u_hit (
    .entry (rd_data),
    .col   (cursor_col),
    .row   (cursor_row),
    .hit   (hit)
  );

  // Handshake and decode helpers
  assign req.ready  = (state == ST_IDLE);
  assign accept     = req.valid && req.ready;
  assign out_free   = !out_valid || rsp.ready;
  assign table_full = (count >= CNT_W'(MAX_WINDOWS));
  assign bad_index  = (CNT_W'(item.remove_index) >= count);
  assign press_walk = item.left_button && !button_was_down && (count != '0);
  assign top_idx    = IDX_W'(count - CNT_W'(1));
  assign ptr_ext    = (CNT_W + 1)'(ptr);
  assign start_more = (ptr_ext + (CNT_W + 1)'(1)) < (CNT_W + 1)'(count);
  assign shift_more = (ptr_ext + (CNT_W + 1)'(2)) < (CNT_W + 1)'(count);
  assign drag_ok    = sel_valid && (CNT_W'(sel_idx) < count);

  // Cursor move: each axis moves only if it lands on screen
  always_comb begin
    lim_w    = (screen_w > SCREEN_CAP) ? SCREEN_CAP : screen_w;
    lim_h    = (screen_h > SCREEN_CAP) ? SCREEN_CAP : screen_h;
    dx_ext   = $signed({{5{item.delta_x[8]}}, item.delta_x});
    dy_ext   = $signed({{5{item.delta_y[8]}}, item.delta_y});
    col_sum  = $signed({2'b00, cursor_col}) + dx_ext;
    row_sum  = $signed({2'b00, cursor_row}) - dy_ext;
    col_next = (!col_sum[13] && (col_sum[12:0] < lim_w)) ? col_sum[11:0] : cursor_col;
    row_next = (!row_sum[13] && (row_sum[12:0] < lim_h)) ? row_sum[11:0] : cursor_row;
  end

  // Dragged window position
  always_comb begin
    drag_x = sat13($signed({rd_data.x[12], rd_data.x}) + dx_ext);
    drag_y = sat13($signed({rd_data.y[12], rd_data.y}) - dy_ext);
  end

  // Selection after a remove
  always_comb begin
    sel_valid_rm = sel_valid;
    sel_idx_rm   = sel_idx;
    if (sel_valid) begin
      if (sel_idx == IDX_W'(item.remove_index)) begin
        sel_valid_rm = 1'b0;
      end else if (sel_idx > IDX_W'(item.remove_index)) begin
        sel_idx_rm = sel_idx - IDX_W'(1);
      end
    end
    if (!sel_valid_rm) begin
      sel_idx_rm = '0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (item.kind)
          KIND_CREATE: state_next = ST_FINISH;
          KIND_REMOVE: state_next = bad_index ? ST_FINISH : ST_REM_CAP;
          KIND_MOUSE:  state_next = press_walk ? ST_HIT : ST_DRAG_CHK;
          default:     state_next = ST_FINISH;
        endcase
      end
      ST_REM_CAP:     state_next = ST_SHIFT_START;
      ST_SHIFT_START: state_next = start_more ? ST_SHIFT : ST_SHIFT_DONE;
      ST_SHIFT:       state_next = shift_more ? ST_SHIFT : ST_SHIFT_DONE;
      ST_SHIFT_DONE: begin
        state_next = (item.kind == KIND_REMOVE) ? ST_FINISH : ST_DRAG_CHK;
      end
      ST_HIT: begin
        if (hit) begin
          state_next = ST_SHIFT_START;
        end else if (ptr == '0) begin
          state_next = ST_DRAG_CHK;
        end
      end
      ST_DRAG_CHK: state_next = drag_ok ? ST_DRAG_WR : ST_FINISH;
      ST_DRAG_WR:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    rd_addr = ptr;
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = rd_data;
    unique case (state)
      ST_DECODE: begin
        if (item.kind == KIND_REMOVE) begin
          rd_addr = IDX_W'(item.remove_index);
        end else if (item.kind == KIND_MOUSE) begin
          rd_addr = top_idx;
        end else if (item.kind == KIND_CREATE && !table_full) begin
          wr_en     = 1'b1;
          wr_addr   = IDX_W'(count);
          wr_data.x = item.pos_x;
          wr_data.y = item.pos_y;
          wr_data.w = item.size_w;
          wr_data.h = item.size_h;
        end
      end
      ST_HIT:         rd_addr = ptr - IDX_W'(1);
      ST_SHIFT_START: rd_addr = ptr + IDX_W'(1);
      ST_SHIFT: begin
        rd_addr = ptr + IDX_W'(2);
        wr_en   = 1'b1;
        wr_addr = ptr;
        wr_data = rd_data;
      end
      ST_SHIFT_DONE: begin
        if (item.kind == KIND_MOUSE) begin
          wr_en   = 1'b1;
          wr_addr = top_idx;
          wr_data = hold;
        end
      end
      ST_DRAG_CHK: rd_addr = sel_idx;
      ST_DRAG_WR: begin
        wr_en     = 1'b1;
        wr_addr   = sel_idx;
        wr_data.x = drag_x;
        wr_data.y = drag_y;
        wr_data.w = rd_data.w;
        wr_data.h = rd_data.h;
      end
      default: begin
        rd_addr = ptr;
      end
    endcase
  end

  // Table memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      count           <= '0;
      cursor_col      <= RST_CURSOR_COL;
      cursor_row      <= RST_CURSOR_ROW;
      button_was_down <= 1'b0;
      sel_valid       <= 1'b0;
      sel_idx         <= '0;
      screen_w        <= RST_SCREEN_W;
      screen_h        <= RST_SCREEN_H;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;

      // Take configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SCREEN_WIDTH:  screen_w <= cfg_data;
          REG_SCREEN_HEIGHT: screen_h <= cfg_data;
          default:           screen_w <= screen_w;
        endcase
      end

      // Drop the result once taken; load a new one at finish
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end

      if (state == ST_DECODE) begin
        if (item.kind == KIND_CREATE && !table_full) begin
          count <= count + CNT_W'(1);
        end
        if (item.kind == KIND_MOUSE) begin
          cursor_col      <= col_next;
          cursor_row      <= row_next;
          button_was_down <= item.left_button;
          if (!item.left_button) begin
            sel_valid <= 1'b0;
            sel_idx   <= '0;
          end
        end
      end

      // Close a remove, or select the window just raised
      if (state == ST_SHIFT_DONE) begin
        if (item.kind == KIND_REMOVE) begin
          count     <= count - CNT_W'(1);
          sel_valid <= sel_valid_rm;
          sel_idx   <= sel_idx_rm;
        end else begin
          sel_valid <= 1'b1;
          sel_idx   <= top_idx;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          item.kind         <= req.kind;
          item.pos_x        <= req.pos_x;
          item.pos_y        <= req.pos_y;
          item.size_w       <= req.size_w;
          item.size_h       <= req.size_h;
          item.remove_index <= req.remove_index;
          item.delta_x      <= req.delta_x;
          item.delta_y      <= req.delta_y;
          item.left_button  <= req.left_button;
        end
      end
      ST_DECODE: begin
        res_status <= STAT_OK;
        res_slot   <= '0;
        res_x      <= '0;
        res_y      <= '0;
        ptr        <= top_idx;
        if (item.kind == KIND_CREATE) begin
          if (table_full) begin
            res_status <= STAT_FULL;
          end else begin
            res_slot <= IDX_W'(count);
            res_x    <= item.pos_x;
            res_y    <= item.pos_y;
          end
        end else if (item.kind == KIND_REMOVE) begin
          res_slot <= IDX_W'(item.remove_index);
          if (bad_index) begin
            res_status <= STAT_BAD_INDEX;
          end
        end
      end
      ST_REM_CAP: begin
        res_x <= rd_data.x;
        res_y <= rd_data.y;
        ptr   <= IDX_W'(item.remove_index);
      end
      ST_SHIFT: begin
        if (shift_more) begin
          ptr <= ptr + IDX_W'(1);
        end
      end
      ST_HIT: begin
        if (hit) begin
          hold <= rd_data;
        end else begin
          ptr <= ptr - IDX_W'(1);
        end
      end
      ST_DRAG_WR: begin
        res_slot <= sel_idx;
        res_x    <= drag_x;
        res_y    <= drag_y;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_status <= res_status;
          out_slot   <= res_slot;
          out_count  <= count;
          out_col    <= cursor_col;
          out_row    <= cursor_row;
          out_drag   <= sel_valid;
          out_x      <= res_x;
          out_y      <= res_y;
        end
      end
      default: begin
        ptr <= ptr;
      end
    endcase
  end

  // Drive the result channel
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.slot         = out_slot;
  assign rsp.window_count = out_count;
  assign rsp.cursor_x     = out_col;
  assign rsp.cursor_y     = out_row;
  assign rsp.drag_active  = out_drag;
  assign rsp.window_x     = out_x;
  assign rsp.window_y     = out_y;

endmodule

/* src/wspd_hit.sv */
// ============================================================================
// wspd_hit
// Cursor-in-rectangle test with inclusive right and bottom edges.
// ============================================================================
module wspd_hit
  import wspd_pkg::*;
(
  input  win_entry_t  entry,
  input  logic [11:0] col,
  input  logic [11:0] row,
  output logic        hit
);

  logic signed [14:0] col_s;
  logic signed [14:0] row_s;
  logic signed [14:0] left;
  logic signed [14:0] top;
  logic signed [14:0] right;
  logic signed [14:0] bottom;

  // Widen everything to one signed width, then bound both axes
  always_comb begin
    col_s  = $signed({3'b000, col});
    row_s  = $signed({3'b000, row});
    left   = $signed({{2{entry.x[12]}}, entry.x});
    top    = $signed({{2{entry.y[12]}}, entry.y});
    right  = left + $signed({3'b000, entry.w});
    bottom = top + $signed({3'b000, entry.h});
    hit    = (col_s >= left) && (col_s <= right) &&
             (row_s >= top) && (row_s <= bottom);
  end

endmodule

/* test/window_stack_pointer_drag_unit_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// window_stack_pointer_drag_unit_tb
// Self-checking bench for the window stack, pointer and drag unit. A scripted
// opening walks empty and full tables, bad removes, the unused kind, press
// edges on window borders, dragging and cursor clamping. Random traffic then
// runs under several screen sizes. Every result is compared field by field
// against an in-bench model of the window stack, or against pinned values.
// ============================================================================
module window_stack_pointer_drag_unit_tb;
  import wspd_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int WIN_POS_MIN = -4096;
  localparam int WIN_POS_MAX = 4095;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 5;

  // One result as the block reports it
  typedef struct {
    logic [1:0]         status;
    logic [3:0]         slot;
    logic [4:0]         count;
    logic [11:0]        cx;
    logic [11:0]        cy;
    logic               drag;
    logic signed [12:0] wx;
    logic signed [12:0] wy;
  } stack_result_t;

  // One line of the scripted opening
  typedef struct {
    item_t         it;
    int            reps;
    bit            typed;
    stack_result_t want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [12:0] cfg_data;

  wspd_req_if req_ch ();
  wspd_rsp_if rsp_ch ();

  window_stack_pointer_drag_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Model of the window stack
  win_entry_t  win_stack [MAX_WINDOWS];
  int          win_count;
  int          cur_col;
  int          cur_row;
  bit          btn_held;
  bit          sel_valid;
  int          sel_idx;
  logic [12:0] scr_w;
  logic [12:0] scr_h;

  stack_result_t pending_results [$];
  stack_result_t pin_want;
  bit            pin_typed;
  int            mismatches;
  int            cycles;
  int            burst_left;
  bit            gaps_on;
  logic [15:0]   stall_pat;
  logic [6:0]    pat_age;

  function automatic logic signed [12:0] clamp13(int v);
    if (v < WIN_POS_MIN) return 13'(WIN_POS_MIN);
    if (v > WIN_POS_MAX) return 13'(WIN_POS_MAX);
    return 13'(v);
  endfunction

  // Move one cursor axis only if it lands on screen
  function automatic int step_axis(int cur, int d, logic [12:0] lim_reg);
    int lim;
    int n;
    lim = (lim_reg > SCREEN_CAP) ? int'(SCREEN_CAP) : int'(lim_reg);
    n = cur + d;
    return (n >= 0 && n < lim) ? n : cur;
  endfunction

  // Inclusive on the left, right, top and bottom edges
  function automatic bit under_cursor(win_entry_t e);
    int x0;
    int y0;
    x0 = int'($signed(e.x));
    y0 = int'($signed(e.y));
    return cur_col >= x0 && cur_col <= x0 + int'(e.w) &&
           cur_row >= y0 && cur_row <= y0 + int'(e.h);
  endfunction

  // Apply one transaction to the model and return its result
  function automatic stack_result_t advance_stack(item_t it);
    stack_result_t r;
    win_entry_t    t;
    int            i;
    int            k;
    int            ri;
    int            dx;
    int            dy;
    bit            found;
    r = '{default: '0};
    case (it.kind)
      KIND_CREATE: begin
        if (win_count >= MAX_WINDOWS) begin
          r.status = STAT_FULL;
        end else begin
          win_stack[win_count] = '{x: it.pos_x, y: it.pos_y, w: it.size_w, h: it.size_h};
          r.slot = 4'(win_count);
          r.wx = it.pos_x;
          r.wy = it.pos_y;
          win_count++;
        end
      end
      KIND_REMOVE: begin
        ri = int'(it.remove_index);
        r.slot = it.remove_index;
        if (ri >= win_count) begin
          r.status = STAT_BAD_INDEX;
        end else begin
          r.wx = win_stack[ri].x;
          r.wy = win_stack[ri].y;
          for (i = ri; i + 1 < win_count; i++) win_stack[i] = win_stack[i + 1];
          win_count--;
          // Drop the selection with its window, or follow it down
          if (sel_valid) begin
            if (sel_idx == ri) sel_valid = 1'b0;
            else if (sel_idx > ri) sel_idx--;
          end
          if (!sel_valid) sel_idx = 0;
        end
      end
      KIND_MOUSE: begin
        dx = int'($signed(it.delta_x));
        dy = int'($signed(it.delta_y));
        cur_col = step_axis(cur_col, dx, scr_w);
        cur_row = step_axis(cur_row, -dy, scr_h);
        if (it.left_button) begin
          // Press edge: hit-test top down, raise the hit window
          if (!btn_held) begin
            found = 1'b0;
            for (k = win_count - 1; k >= 0 && !found; k--) begin
              if (under_cursor(win_stack[k])) begin
                t = win_stack[k];
                for (i = k; i + 1 < win_count; i++) win_stack[i] = win_stack[i + 1];
                win_stack[win_count - 1] = t;
                sel_valid = 1'b1;
                sel_idx = win_count - 1;
                found = 1'b1;
              end
            end
          end
        end else begin
          sel_valid = 1'b0;
          sel_idx = 0;
        end
        if (sel_valid && sel_idx < win_count) begin
          win_stack[sel_idx].x = clamp13(int'($signed(win_stack[sel_idx].x)) + dx);
          win_stack[sel_idx].y = clamp13(int'($signed(win_stack[sel_idx].y)) - dy);
          r.slot = 4'(sel_idx);
          r.wx = win_stack[sel_idx].x;
          r.wy = win_stack[sel_idx].y;
        end
        btn_held = it.left_button;
      end
      default: begin
      end
    endcase
    r.count = 5'(win_count);
    r.cx = 12'(cur_col);
    r.cy = 12'(cur_row);
    r.drag = sel_valid;
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Watch both channels and the register port at each edge
  always @(posedge clk) begin : watch
    stack_result_t want;
    item_t         it;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual status %0d slot %0d",
                   $time, rsp_ch.status, rsp_ch.slot);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, rsp_ch.status);
          check_field("slot", want.slot, rsp_ch.slot);
          check_field("window_count", want.count, rsp_ch.window_count);
          check_field("cursor_x", want.cx, rsp_ch.cursor_x);
          check_field("cursor_y", want.cy, rsp_ch.cursor_y);
          check_field("drag_active", want.drag, rsp_ch.drag_active);
          check_field("window_x", $signed(want.wx), $signed(rsp_ch.window_x));
          check_field("window_y", $signed(want.wy), $signed(rsp_ch.window_y));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  scr_w = cfg_data;
          REG_SCREEN_HEIGHT: scr_h = cfg_data;
          default: begin
          end
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        it.kind = req_ch.kind;
        it.pos_x = req_ch.pos_x;
        it.pos_y = req_ch.pos_y;
        it.size_w = req_ch.size_w;
        it.size_h = req_ch.size_h;
        it.remove_index = req_ch.remove_index;
        it.delta_x = req_ch.delta_x;
        it.delta_y = req_ch.delta_y;
        it.left_button = req_ch.left_button;
        want = advance_stack(it);
        if (pin_typed) want = pin_want;
        pending_results.push_back(want);
      end
    end
  end

  // Receiver stalls on a rotating pattern, reloaded now and then
  always @(posedge clk) begin
    if (pat_age == '0) begin
      stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0001;
    end else begin
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
    end
    pat_age <= pat_age + 7'd1;
    rsp_ch.ready <= stall_pat[15];
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic script_row_t scripted(logic [1:0] kind, int px, int py, int w, int h,
                                           int ri, int dx, int dy, bit btn, int reps);
    script_row_t s;
    s.it.kind = kind;
    s.it.pos_x = 13'(px);
    s.it.pos_y = 13'(py);
    s.it.size_w = 12'(w);
    s.it.size_h = 12'(h);
    s.it.remove_index = 4'(ri);
    s.it.delta_x = 9'(dx);
    s.it.delta_y = 9'(dy);
    s.it.left_button = btn;
    s.reps = reps;
    s.typed = 1'b0;
    s.want = '{default: '0};
    return s;
  endfunction

  function automatic script_row_t pinned(script_row_t s, logic [1:0] st, int slot, int cnt,
                                         int cx, int cy, bit drag, int wx, int wy);
    s.typed = 1'b1;
    s.want = '{status: st, slot: 4'(slot), count: 5'(cnt), cx: 12'(cx), cy: 12'(cy),
               drag: drag, wx: 13'(wx), wy: 13'(wy)};
    return s;
  endfunction

  // Random item, biased toward windows under the cursor and press-drag runs
  function automatic item_t gen_item();
    item_t it;
    int    sel;
    int    w;
    int    h;
    it.kind = KIND_MOUSE;
    it.pos_x = 13'($urandom);
    it.pos_y = 13'($urandom);
    it.size_w = 12'($urandom);
    it.size_h = 12'($urandom);
    it.remove_index = 4'($urandom);
    it.delta_x = 9'($urandom);
    it.delta_y = 9'($urandom);
    it.left_button = 1'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      it.kind = KIND_UNUSED;
    end else if (sel < ((win_count < 10) ? 34 : 18)) begin
      it.kind = KIND_CREATE;
      case ($urandom_range(0, 3))
        0, 1: begin
          w = $urandom_range(0, 400);
          h = $urandom_range(0, 400);
          it.size_w = 12'(w);
          it.size_h = 12'(h);
          it.pos_x = 13'(cur_col - int'($urandom_range(0, w)));
          it.pos_y = 13'(cur_row - int'($urandom_range(0, h)));
        end
        2: begin
        end
        default: begin
          it.pos_x = $urandom_range(0, 1) ? 13'(WIN_POS_MAX - int'($urandom_range(0, 150)))
                                          : 13'(WIN_POS_MIN + int'($urandom_range(0, 150)));
          it.pos_y = $urandom_range(0, 1) ? 13'(WIN_POS_MAX - int'($urandom_range(0, 150)))
                                          : 13'(WIN_POS_MIN + int'($urandom_range(0, 150)));
          it.size_w = 12'($urandom_range(3900, 4095));
          it.size_h = 12'($urandom_range(3900, 4095));
        end
      endcase
    end else if (sel < 50) begin
      it.kind = KIND_REMOVE;
      if (win_count > 0 && $urandom_range(0, 3) != 0)
        it.remove_index = 4'($urandom_range(0, win_count - 1));
    end else begin
      // Hold a pressed button for a while, press fairly often
      if (btn_held) it.left_button = ($urandom_range(0, 3) != 0);
      else it.left_button = ($urandom_range(0, 9) < 4);
      if ($urandom_range(0, 9) < 7) begin
        it.delta_x = 9'(int'($urandom_range(0, 40)) - 20);
        it.delta_y = 9'(int'($urandom_range(0, 40)) - 20);
      end
    end
    return it;
  endfunction

  // Present one transaction and hold it until accepted
  task automatic push_item(item_t it, bit typed, stack_result_t want);
    req_ch.valid <= 1'b1;
    req_ch.kind <= it.kind;
    req_ch.pos_x <= it.pos_x;
    req_ch.pos_y <= it.pos_y;
    req_ch.size_w <= it.size_w;
    req_ch.size_h <= it.size_h;
    req_ch.remove_index <= it.remove_index;
    req_ch.delta_x <= it.delta_x;
    req_ch.delta_y <= it.delta_y;
    req_ch.left_button <= it.left_button;
    pin_typed <= typed;
    pin_want <= want;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // After a transaction: drop valid and drain, or go on with the burst
  task automatic after_item(bit drain);
    if (drain) begin
      req_ch.valid <= 1'b0;
      wait_idle();
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic set_screen(logic [12:0] w, logic [12:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    script_row_t   script [$];
    stack_result_t blank;
    logic [12:0]   phase_w [NUM_PHASES];
    logic [12:0]   phase_h [NUM_PHASES];
    int            phase_n [NUM_PHASES];
    int            p;
    int            n;
    int            r;

    // Known values on every input from time zero
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_SCREEN_WIDTH;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_CREATE;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
    req_ch.size_w = '0;
    req_ch.size_h = '0;
    req_ch.remove_index = '0;
    req_ch.delta_x = '0;
    req_ch.delta_y = '0;
    req_ch.left_button = 1'b0;
    rsp_ch.ready = 1'b0;
    stall_pat = 16'hFFFF;
    pat_age = 7'd1;
    pin_typed = 1'b0;
    mismatches = 0;
    cycles = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    blank = '{default: '0};
    pin_want = blank;

    // Model reset state
    foreach (win_stack[i]) win_stack[i] = '0;
    win_count = 0;
    cur_col = int'(RST_CURSOR_COL);
    cur_row = int'(RST_CURSOR_ROW);
    btn_held = 1'b0;
    sel_valid = 1'b0;
    sel_idx = 0;
    scr_w = RST_SCREEN_W;
    scr_h = RST_SCREEN_H;

    // Opening script: empty table, unused kind, border hit, fill, drag clamp
    script.push_back(pinned(scripted(KIND_MOUSE, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1),
                            STAT_OK, 0, 0, RST_CURSOR_COL, RST_CURSOR_ROW, 1'b0, 0, 0));
    script.push_back(pinned(scripted(KIND_REMOVE, 0, 0, 0, 0, 15, 0, 0, 1'b0, 1),
                            STAT_BAD_INDEX, 15, 0, RST_CURSOR_COL, RST_CURSOR_ROW, 1'b0, 0, 0));
    script.push_back(pinned(scripted(KIND_UNUSED, 1, 2, 3, 4, 5, 100, -100, 1'b1, 1),
                            STAT_OK, 0, 0, RST_CURSOR_COL, RST_CURSOR_ROW, 1'b0, 0, 0));
    script.push_back(pinned(scripted(KIND_MOUSE, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1),
                            STAT_OK, 0, 0, RST_CURSOR_COL, RST_CURSOR_ROW, 1'b0, 0, 0));
    script.push_back(pinned(scripted(KIND_MOUSE, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1),
                            STAT_OK, 0, 0, RST_CURSOR_COL, RST_CURSOR_ROW, 1'b0, 0, 0));
    script.push_back(pinned(scripted(KIND_CREATE, -4096, -4096, 4095, 4095, 0, 0, 0, 1'b0, 1),
                            STAT_OK, 0, 1, RST_CURSOR_COL, RST_CURSOR_ROW, 1'b0, -4096, -4096));
    script.push_back(pinned(scripted(KIND_CREATE, 4095, 4095, 0, 0, 0, 0, 0, 1'b0, 1),
                            STAT_OK, 1, 2, RST_CURSOR_COL, RST_CURSOR_ROW, 1'b0, 4095, 4095));
    // Right and bottom edges land exactly on the cursor
    script.push_back(scripted(KIND_CREATE, 500, 380, 12, 4, 0, 0, 0, 1'b0, 1));
    script.push_back(scripted(KIND_CREATE, 600, 600, 50, 50, 0, 0, 0, 1'b0, 1));
    script.push_back(scripted(KIND_MOUSE, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1));
    script.push_back(scripted(KIND_MOUSE, 0, 0, 0, 0, 0, 255, 255, 1'b1, 1));
    script.push_back(scripted(KIND_CREATE, 100, 100, 50, 50, 0, 0, 0, 1'b1, 12));
    script.push_back(scripted(KIND_CREATE, 0, 0, 10, 10, 0, 0, 0, 1'b1, 1));
    // Remove below the selection, then the selection itself
    script.push_back(scripted(KIND_REMOVE, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1));
    script.push_back(scripted(KIND_REMOVE, 0, 0, 0, 0, 2, 0, 0, 1'b1, 1));
    script.push_back(scripted(KIND_MOUSE, 0, 0, 0, 0, 0, 5, 0, 1'b1, 1));
    script.push_back(scripted(KIND_MOUSE, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1));
    // Move the cursor toward the left and bottom edges
    script.push_back(scripted(KIND_MOUSE, 0, 0, 0, 0, 0, -256, 0, 1'b0, 3));
    script.push_back(scripted(KIND_MOUSE, 0, 0, 0, 0, 0, 0, -256, 1'b0, 2));
    // Drag a window past the left limit
    script.push_back(scripted(KIND_CREATE, -3800, -3400, 4095, 4095, 0, 0, 0, 1'b0, 1));
    script.push_back(scripted(KIND_MOUSE, 0, 0, 0, 0, 0, -256, 0, 1'b1, 1));
    script.push_back(scripted(KIND_MOUSE, 0, 0, 0, 0, 0, -256, 255, 1'b1, 1));
    script.push_back(scripted(KIND_MOUSE, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1));

    // Screen settings per random phase, extremes first
    phase_w = '{13'd4096, 13'd1, 13'd8191, 13'd640, 13'($urandom_range(0, 8191))};
    phase_h = '{13'd4096, 13'd1, 13'd0, 13'd480, 13'($urandom_range(0, 8191))};
    phase_n = '{110, 70, 110, 130, 130};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      for (r = 0; r < script[i].reps; r++) begin
        push_item(script[i].it, script[i].typed, script[i].want);
        after_item(i == script.size() - 1 && r == script[i].reps - 1);
      end
    end

    // Random phases; the block is drained before each register write
    for (p = 0; p < NUM_PHASES; p++) begin
      set_screen(phase_w[p], phase_h[p]);
      gaps_on = (p != 0);
      for (n = 0; n < phase_n[p]; n++) begin
        push_item(gen_item(), 1'b0, blank);
        after_item(n == phase_n[p] / 2 || n == phase_n[p] - 1);
      end
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
